FILE: hdl/mouse_click_double_click_qualifier_defines.svh
// Assertion macros used by the mouse click qualifier checker.
`ifndef MOUSE_CLICK_DOUBLE_CLICK_QUALIFIER_DEFINES_SVH
`define MOUSE_CLICK_DOUBLE_CLICK_QUALIFIER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define MCDQ_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define MCDQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/mcdq_pkg.sv
// Package with the payload types and constants of the mouse click qualifier.
`timescale 1ns / 1ps
package mcdq_pkg;

    localparam int unsigned NUM_BUTTONS = 3;
    localparam logic [31:0] DEFAULT_WINDOW = 32'd500;

    typedef struct packed {
        logic                   enabled;
        logic [NUM_BUTTONS-1:0] buttons;
        logic                   moved;
        logic [31:0]            now_ms;
    } in_t;

    typedef struct packed {
        logic                   move_event;
        logic                   any_down;
        logic [NUM_BUTTONS-1:0] down_mask;
        logic [NUM_BUTTONS-1:0] dbl_mask;
        logic [NUM_BUTTONS-1:0] up_mask;
        logic [NUM_BUTTONS-1:0] held_mask;
    } out_t;

endpackage

FILE: hdl/mouse_click_double_click_qualifier.sv
// Top level of the mouse click and double click qualifier.
//
//   channel   ports                      carries
//   input     s_valid s_ready s_data     one mouse poll per transaction
//   result    m_valid m_ready m_data     one event record per poll
//   config    cfg_valid cfg_ready cfg_data  the double click window in ms
//
// A poll is evaluated in the cycle it is accepted and its result is registered,
// so the result appears in the cycle after; one poll can be taken in every cycle unless the result register holds.
// The state registers update at acceptance of an enabled poll, so the next poll sees them at once.
// The result register holds while m_valid is high and m_ready is low; s_ready then follows m_ready.
// aresetn is synchronous and active low; the window returns to 500 ms.
`timescale 1ns / 1ps
module mouse_click_double_click_qualifier (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  mcdq_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output mcdq_pkg::out_t  m_data,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [31:0]     cfg_data
);
    import mcdq_pkg::*;

    logic [31:0]            window_reg;
    logic [NUM_BUTTONS-1:0] prev_buttons_reg;
    logic [31:0]            last_press_time_reg;
    logic [31:0]            dbl_stamp_time_reg;
    logic                   dbl_latched_reg;
    logic                   dbl_armed_reg;
    logic                   m_valid_reg;
    out_t                   m_data_reg;

    logic                   accept;
    logic [31:0]            since_press;
    logic [31:0]            since_stamp;
    logic                   press_in_window;
    logic                   stamp_expired;
    logic                   window_zero;
    logic [NUM_BUTTONS-1:0] press_edge;
    logic [NUM_BUTTONS-1:0] release_edge;
    logic [NUM_BUTTONS-1:0] held;
    logic [NUM_BUTTONS-1:0] dbl;
    logic                   lt_now;
    logic                   expired_now;
    logic                   armed_next;
    logic                   latched_next;
    logic                   set_stamp;
    out_t                   m_data_next;

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign since_press     = s_data.now_ms - last_press_time_reg;
    assign since_stamp     = s_data.now_ms - dbl_stamp_time_reg;
    assign press_in_window = since_press < window_reg;
    assign stamp_expired   = since_stamp > window_reg;
    assign window_zero     = window_reg == '0;
    assign press_edge      = s_data.buttons & ~prev_buttons_reg;
    assign release_edge    = ~s_data.buttons & prev_buttons_reg;
    assign held            = s_data.buttons & prev_buttons_reg;

    // After the first press of a poll the press time equals now, so later
    // buttons see a zero difference; the stamp is fresh only once a button set it.
    always_comb begin
        lt_now       = press_in_window;
        expired_now  = stamp_expired;
        armed_next   = dbl_armed_reg && !s_data.moved;
        latched_next = dbl_latched_reg;
        set_stamp    = 1'b0;
        dbl          = '0;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            if (press_edge[i]) begin
                if (lt_now) begin
                    if (!s_data.moved && armed_next) begin
                        if (latched_next && expired_now) begin
                            latched_next = 1'b0;
                        end
                        if (!latched_next) begin
                            latched_next = 1'b1;
                            expired_now  = 1'b0;
                            set_stamp    = 1'b1;
                            dbl[i]       = 1'b1;
                        end
                    end
                end else begin
                    latched_next = 1'b0;
                end
                lt_now     = !window_zero;
                armed_next = 1'b1;
            end
        end
    end

    always_comb begin
        m_data_next = '0;
        if (s_data.enabled) begin
            m_data_next.move_event = s_data.moved;
            m_data_next.any_down   = |press_edge;
            m_data_next.down_mask  = press_edge;
            m_data_next.dbl_mask   = dbl;
            m_data_next.up_mask    = release_edge;
            m_data_next.held_mask  = held;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg          <= DEFAULT_WINDOW;
            prev_buttons_reg    <= '0;
            last_press_time_reg <= '0;
            dbl_stamp_time_reg  <= '0;
            dbl_latched_reg     <= 1'b0;
            dbl_armed_reg       <= 1'b0;
            m_valid_reg         <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                window_reg <= cfg_data;
            end
            if (accept && s_data.enabled) begin
                prev_buttons_reg <= s_data.buttons;
                dbl_latched_reg  <= latched_next;
                dbl_armed_reg    <= armed_next;
                if (|press_edge) begin
                    last_press_time_reg <= s_data.now_ms;
                end
                if (set_stamp) begin
                    dbl_stamp_time_reg <= s_data.now_ms;
                end
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

FILE: hdl/mcdq_checker.sv
// Port-level checker for the mouse click qualifier, bound to the top level.
`timescale 1ns / 1ps
`include "mouse_click_double_click_qualifier_defines.svh"
module mcdq_checker (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    input  logic            s_ready,
    input  mcdq_pkg::in_t   s_data,
    input  logic            m_valid,
    input  logic            m_ready,
    input  mcdq_pkg::out_t  m_data,
    input  logic            cfg_valid,
    input  logic            cfg_ready,
    input  logic [31:0]     cfg_data
);
    import mcdq_pkg::*;

    `MCDQ_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_data), "Result transaction changed while stalled.")
    `MCDQ_ASSERT_NOW(a_any_down, aclk, aresetn, m_valid,
        m_data.any_down == (m_data.down_mask != '0), "any_down disagrees with down_mask.")
    `MCDQ_ASSERT_NOW(a_dbl_on_press, aclk, aresetn, m_valid,
        (m_data.dbl_mask & ~m_data.down_mask) == '0, "Double click without a press edge.")
    `MCDQ_ASSERT_NOW(a_edges_exclusive, aclk, aresetn, m_valid,
        ((m_data.down_mask | m_data.up_mask) & m_data.held_mask) == '0
        && (m_data.down_mask & m_data.up_mask) == '0, "Button edge masks overlap.")
    `MCDQ_ASSERT_NOW(a_no_dbl_on_move, aclk, aresetn, m_valid && m_data.move_event,
        m_data.dbl_mask == '0, "Double click reported in a poll with motion.")

endmodule

bind mouse_click_double_click_qualifier mcdq_checker u_mcdq_checker (.*);
